@@ hw/rtl/bpa_pkg.sv @@
// shared types, constants and helper functions of the page bitmap allocator
package bpa_pkg;

  localparam int unsigned MaxPagesDef = 65536;
  localparam int unsigned WordBits    = 32;
  localparam int unsigned PageW       = 20;
  localparam int unsigned CountW      = 17;
  localparam int unsigned GotW        = 16;
  localparam int unsigned StatusW     = 3;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 20;
  localparam int unsigned NumW        = 21;

  localparam logic [PageW-1:0]  KernFirst     = PageW'(32'h0010_0000 >> 12);
  localparam logic [PageW-1:0]  KernLast      = PageW'(32'h0060_0000 >> 12);
  localparam logic [PageW-1:0]  ResvFirstRst  = '1;
  localparam logic [PageW-1:0]  ResvLastRst   = '0;
  localparam logic [CountW-1:0] PageCountRst  = CountW'(65536);

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_RANGE     = 3'd1,
    ST_NOT_ALLOC = 3'd2,
    ST_RESERVED  = 3'd3,
    ST_NO_FREE   = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAGE_COUNT = 3'd0,
    CFG_RESV0_FIRST = 3'd1,
    CFG_RESV0_LAST  = 3'd2,
    CFG_RESV1_FIRST = 3'd3,
    CFG_RESV1_LAST  = 3'd4,
    CFG_RESV2_FIRST = 3'd5,
    CFG_RESV2_LAST  = 3'd6
  } cfg_idx_e;

  typedef enum logic [0:0] {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  typedef struct packed {
    logic             req_type;
    logic [PageW-1:0] free_page;
  } req_t;

  typedef struct packed {
    logic [GotW-1:0]    got_page;
    logic [StatusW-1:0] status;
  } rsp_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic free_rd;
    logic free_chk;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic free_oor;
  } sts_t;

  // bits of word w whose page lies in [first, last]
  function automatic logic [WordBits-1:0] range_mask(logic [14:0] w,
                                                     logic [PageW-1:0] first,
                                                     logic [PageW-1:0] last);
    logic [14:0]         fw;
    logic [14:0]         lw;
    logic [4:0]          lo;
    logic [4:0]          hi;
    logic [WordBits-1:0] m;
    fw = first[PageW-1:5];
    lw = last[PageW-1:5];
    lo = (fw == w) ? first[4:0] : 5'd0;
    hi = (lw == w) ? last[4:0] : 5'd31;
    m  = ({WordBits{1'b1}} << lo) & ({WordBits{1'b1}} >> (5'd31 - hi));
    if (first > last || fw > w || lw < w) begin
      m = '0;
    end
    return m;
  endfunction

  function automatic logic in_range(logic [PageW-1:0] p, logic [PageW-1:0] first,
                                    logic [PageW-1:0] last);
    return (p >= first) && (p <= last);
  endfunction

endpackage

@@ hw/rtl/bitmap_page_allocator_unit.sv @@
// top level of the page bitmap allocator
//
//   channel   ports                                  direction
//   request   start_i, busy_o, req_i                 in (busy_o out)
//   result    done_o, rsp_o                          out
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i       in
//
// after reset a clearing pass zeroes the bitmap ram, one word a cycle, over all
// MaxPages/32 words; busy_o is high and config is taken.
// allocate: one bitmap word read per cycle over up to MaxPages/32 words; the
// result strobe comes at the first free unreserved page or at the end of the range.
// free: one ram read, skipped for a page out of range, then the result strobe.
// done_o is high for one cycle; results cannot be stalled.
module bitmap_page_allocator_unit #(
  parameter int unsigned MaxPages = bpa_pkg::MaxPagesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  bpa_pkg::req_t                req_i,
  output logic                         done_o,
  output bpa_pkg::rsp_t                rsp_o,
  input  logic                         cfg_we_i,
  input  logic [bpa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpa_pkg::CfgDataW-1:0] cfg_wdata_i
);

  bpa_pkg::cmd_t cmd;
  bpa_pkg::sts_t sts;

  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_free_i (req_i.req_type == bpa_pkg::REQ_FREE),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  bpa_datapath #(
    .MaxPages (MaxPages)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

endmodule

@@ hw/rtl/bpa_ram.sv @@
// generic single write port, single read port ram with registered read
module bpa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bpa_datapath.sv @@
// allocator datapath: config registers, bitmap ram, scan and free checks
module bpa_datapath #(
  parameter int unsigned MaxPages = bpa_pkg::MaxPagesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpa_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpa_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  bpa_pkg::req_t                 req_i,
  input  bpa_pkg::cmd_t                 cmd_i,
  output bpa_pkg::sts_t                 sts_o,
  output logic                          done_o,
  output bpa_pkg::rsp_t                 rsp_o
);

  localparam int unsigned PW        = $clog2(MaxPages);
  localparam int unsigned WAW       = PW - 5;
  localparam int unsigned WordCount = (MaxPages + bpa_pkg::WordBits - 1) / bpa_pkg::WordBits;
  localparam int unsigned WB        = bpa_pkg::WordBits;

  // configuration
  logic [bpa_pkg::CountW-1:0] page_count_q;
  logic [bpa_pkg::PageW-1:0]  resv_first_q [3];
  logic [bpa_pkg::PageW-1:0]  resv_last_q  [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q <= bpa_pkg::PageCountRst;
      for (int r = 0; r < 3; r++) begin
        resv_first_q[r] <= bpa_pkg::ResvFirstRst;
        resv_last_q[r]  <= bpa_pkg::ResvLastRst;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpa_pkg::CFG_PAGE_COUNT:  page_count_q    <= cfg_wdata_i[bpa_pkg::CountW-1:0];
        bpa_pkg::CFG_RESV0_FIRST: resv_first_q[0] <= cfg_wdata_i;
        bpa_pkg::CFG_RESV0_LAST:  resv_last_q[0]  <= cfg_wdata_i;
        bpa_pkg::CFG_RESV1_FIRST: resv_first_q[1] <= cfg_wdata_i;
        bpa_pkg::CFG_RESV1_LAST:  resv_last_q[1]  <= cfg_wdata_i;
        bpa_pkg::CFG_RESV2_FIRST: resv_first_q[2] <= cfg_wdata_i;
        bpa_pkg::CFG_RESV2_LAST:  resv_last_q[2]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // effective page count, clamped to the bitmap size
  logic [bpa_pkg::NumW-1:0] cnt_ext;
  logic [bpa_pkg::NumW-1:0] num_pages;
  assign cnt_ext   = bpa_pkg::NumW'(page_count_q);
  assign num_pages = (cnt_ext > bpa_pkg::NumW'(MaxPages)) ? bpa_pkg::NumW'(MaxPages) : cnt_ext;

  // request, pointer and scan pipeline registers
  logic [bpa_pkg::PageW-1:0] page_q;
  logic [WAW:0]              ptr_q, ptr_d;
  logic                      pend_q, pend_d;
  logic [WAW-1:0]            pend_word_q;
  logic [WB-1:0]             elig_q;
  logic                      done_q, done_d;
  bpa_pkg::rsp_t             rsp_q, rsp_d;

  logic           ram_we;
  logic [WAW-1:0] ram_waddr;
  logic [WB-1:0]  ram_wdata;
  logic           ram_re;
  logic [WAW-1:0] ram_raddr;
  logic [WB-1:0]  ram_rdata;

  bpa_ram #(
    .Width (WB),
    .Depth (WordCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // eligibility of the word at the pointer: in range and not reserved
  logic [14:0]   ptr_w15;
  logic [15:0]   ptr_w16;
  logic [15:0]   num_w;
  logic [WB-1:0] cnt_mask;
  logic [WB-1:0] resv_mask;
  logic [WB-1:0] elig;

  assign ptr_w15 = 15'(ptr_q[WAW-1:0]);
  assign ptr_w16 = 16'(ptr_q[WAW-1:0]);
  assign num_w   = num_pages[bpa_pkg::NumW-1:5];

  always_comb begin
    if (ptr_w16 < num_w) begin
      cnt_mask = '1;
    end else if (ptr_w16 == num_w) begin
      cnt_mask = ~({WB{1'b1}} << num_pages[4:0]);
    end else begin
      cnt_mask = '0;
    end
    resv_mask = bpa_pkg::range_mask(ptr_w15, bpa_pkg::KernFirst, bpa_pkg::KernLast);
    for (int r = 0; r < 3; r++) begin
      resv_mask = resv_mask | bpa_pkg::range_mask(ptr_w15, resv_first_q[r], resv_last_q[r]);
    end
    elig = cnt_mask & ~resv_mask;
  end

  // check of the word read in the previous cycle
  logic [WB-1:0] free_bits;
  logic          hit;
  logic [4:0]    hit_idx;
  logic [PW-1:0] hit_page;
  logic          issue;

  always_comb begin
    free_bits = elig_q & ~ram_rdata;
    hit       = pend_q && (free_bits != '0);
    hit_idx   = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        hit_idx = 5'(i);
      end
    end
  end

  assign hit_page = {pend_word_q, hit_idx};
  assign issue    = ({ptr_q, 5'b0} < (PW + 1)'(num_pages)) && !hit;

  // free request checks
  logic free_oor;
  logic free_set;
  logic free_resv;

  assign free_oor  = bpa_pkg::NumW'(page_q) >= num_pages;
  assign free_set  = ram_rdata[page_q[4:0]];
  assign free_resv = bpa_pkg::in_range(page_q, bpa_pkg::KernFirst, bpa_pkg::KernLast)
                  || bpa_pkg::in_range(page_q, resv_first_q[0], resv_last_q[0])
                  || bpa_pkg::in_range(page_q, resv_first_q[1], resv_last_q[1])
                  || bpa_pkg::in_range(page_q, resv_first_q[2], resv_last_q[2]);

  always_comb begin
    ptr_d     = ptr_q;
    pend_d    = pend_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q[WAW-1:0];
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = ptr_q[WAW-1:0];
    if (cmd_i.clr) begin
      ram_we = 1'b1;
      ptr_d  = ptr_q + 1'b1;
    end
    if (cmd_i.load) begin
      ptr_d  = '0;
      pend_d = 1'b0;
    end
    if (cmd_i.scan) begin
      pend_d = issue;
      if (issue) begin
        ram_re = 1'b1;
        ptr_d  = ptr_q + 1'b1;
      end
      if (hit) begin
        ram_we         = 1'b1;
        ram_waddr      = pend_word_q;
        ram_wdata      = ram_rdata | (WB'(1) << hit_idx);
        done_d         = 1'b1;
        rsp_d.got_page = 16'(hit_page);
        rsp_d.status   = bpa_pkg::ST_OK;
      end else if (!issue) begin
        done_d         = 1'b1;
        rsp_d.got_page = '0;
        rsp_d.status   = bpa_pkg::ST_NO_FREE;
      end
    end
    if (cmd_i.free_rd) begin
      ram_raddr = page_q[WAW+4:5];
      if (free_oor) begin
        done_d         = 1'b1;
        rsp_d.got_page = '0;
        rsp_d.status   = bpa_pkg::ST_RANGE;
      end else begin
        ram_re = 1'b1;
      end
    end
    if (cmd_i.free_chk) begin
      done_d         = 1'b1;
      rsp_d.got_page = '0;
      ram_waddr      = page_q[WAW+4:5];
      ram_wdata      = ram_rdata & ~(WB'(1) << page_q[4:0]);
      if (!free_set) begin
        rsp_d.status = bpa_pkg::ST_NOT_ALLOC;
      end else if (free_resv) begin
        rsp_d.status = bpa_pkg::ST_RESERVED;
      end else begin
        rsp_d.status = bpa_pkg::ST_OK;
        ram_we       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      ptr_q  <= ptr_d;
      pend_q <= pend_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q       <= rsp_d;
    pend_word_q <= ptr_q[WAW-1:0];
    elig_q      <= elig;
    if (cmd_i.load) begin
      page_q <= req_i.free_page;
    end
  end

  assign sts_o.clr_last  = (ptr_q[WAW-1:0] == WAW'(WordCount - 1));
  assign sts_o.scan_done = hit || !issue;
  assign sts_o.free_oor  = free_oor;
  assign done_o          = done_q;
  assign rsp_o           = rsp_q;

endmodule

@@ hw/rtl/bpa_ctrl.sv @@
// allocator control state machine
module bpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          req_free_i,
  input  bpa_pkg::sts_t sts_i,
  output bpa_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  typedef enum logic [4:0] {
    S_CLEAR    = 5'b00001,
    S_IDLE     = 5'b00010,
    S_SCAN     = 5'b00100,
    S_FREE_RD  = 5'b01000,
    S_FREE_CHK = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = req_free_i ? S_FREE_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_IDLE;
        end
      end
      S_FREE_RD: begin
        cmd_o.free_rd = 1'b1;
        state_d       = sts_i.free_oor ? S_IDLE : S_FREE_CHK;
      end
      S_FREE_CHK: begin
        cmd_o.free_chk = 1'b1;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

@@ sim/tb_bitmap_page_allocator_unit.sv @@
// testbench for the page bitmap allocator: directed and random requests, scored
`timescale 1ns / 1ps

module tb_bitmap_page_allocator_unit;

  localparam int unsigned NumPages     = bpa_pkg::MaxPagesDef;
  localparam int unsigned CycleLimit   = 3000000;
  localparam int unsigned TailCycles   = 2100;
  localparam logic [bpa_pkg::CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  bpa_pkg::req_t                req_i;
  logic                         done_o;
  bpa_pkg::rsp_t                rsp_o;
  logic                         cfg_we_i;
  logic [bpa_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [bpa_pkg::CfgDataW-1:0] cfg_wdata_i;

  bitmap_page_allocator_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // shadow of the allocator state
  bit                         page_map[NumPages];
  logic [bpa_pkg::CountW-1:0] page_count;
  logic [bpa_pkg::PageW-1:0]  resv_first[3];
  logic [bpa_pkg::PageW-1:0]  resv_last[3];

  bpa_pkg::rsp_t     pending_rsp_q[$];
  int unsigned       granted_q[$];
  int unsigned       err_cnt;
  int unsigned       cycle_cnt;
  int unsigned       idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit page_reserved(int unsigned p);
    bit hit;
    hit = (p >= bpa_pkg::KernFirst) && (p <= bpa_pkg::KernLast);
    for (int r = 0; r < 3; r++) begin
      if (p >= resv_first[r] && p <= resv_last[r]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic int unsigned usable_pages();
    return (page_count > NumPages) ? NumPages : int'(page_count);
  endfunction

  function automatic bpa_pkg::rsp_t predict_rsp(bpa_pkg::req_t r);
    bpa_pkg::rsp_t e;
    int unsigned   n;
    int unsigned   p;
    n = usable_pages();
    e.got_page = '0;
    if (r.req_type == bpa_pkg::REQ_ALLOC) begin
      e.status = bpa_pkg::ST_NO_FREE;
      for (p = 0; p < n; p++) begin
        if (!page_reserved(p) && !page_map[p]) begin
          page_map[p] = 1'b1;
          e.got_page  = bpa_pkg::GotW'(p);
          e.status    = bpa_pkg::ST_OK;
          granted_q.push_back(p);
          break;
        end
      end
    end else begin
      p = r.free_page;
      if (p >= n) begin
        e.status = bpa_pkg::ST_RANGE;
      end else if (!page_map[p]) begin
        e.status = bpa_pkg::ST_NOT_ALLOC;
      end else if (page_reserved(p)) begin
        e.status = bpa_pkg::ST_RESERVED;
      end else begin
        page_map[p] = 1'b0;
        e.status    = bpa_pkg::ST_OK;
      end
    end
    return e;
  endfunction

  always @(posedge clk_i) begin
    bpa_pkg::rsp_t e;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_ni && done_o) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: unexpected result got_page=%0d status=%0d", $time,
                 rsp_o.got_page, rsp_o.status);
        err_cnt++;
      end else begin
        e = pending_rsp_q.pop_front();
        if (rsp_o.got_page !== e.got_page) begin
          $display("%0t: got_page expected %0d actual %0d", $time, e.got_page,
                   rsp_o.got_page);
          err_cnt++;
        end
        if (rsp_o.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $time, e.status,
                   rsp_o.status);
          err_cnt++;
        end
      end
    end
  end

  // one request; start stays high afterwards until the next negedge drive
  task automatic send_req(bpa_pkg::req_type_e kind, logic [bpa_pkg::PageW-1:0] page);
    bpa_pkg::req_t r;
    r.req_type  = kind;
    r.free_page = page;
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= r;
    forever begin
      @(posedge clk_i);
      if (!busy_o) begin
        pending_rsp_q.push_back(predict_rsp(r));
        break;
      end
    end
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat ($urandom_range(6)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    wait (pending_rsp_q.size() == 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(bpa_pkg::cfg_idx_e idx, logic [bpa_pkg::CfgDataW-1:0] data);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      bpa_pkg::CFG_PAGE_COUNT:  page_count    = data[bpa_pkg::CountW-1:0];
      bpa_pkg::CFG_RESV0_FIRST: resv_first[0] = data;
      bpa_pkg::CFG_RESV0_LAST:  resv_last[0]  = data;
      bpa_pkg::CFG_RESV1_FIRST: resv_first[1] = data;
      bpa_pkg::CFG_RESV1_LAST:  resv_last[1]  = data;
      bpa_pkg::CFG_RESV2_FIRST: resv_first[2] = data;
      bpa_pkg::CFG_RESV2_LAST:  resv_last[2]  = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic clear_ranges();
    write_cfg(bpa_pkg::CFG_RESV0_FIRST, bpa_pkg::ResvFirstRst);
    write_cfg(bpa_pkg::CFG_RESV0_LAST, bpa_pkg::ResvLastRst);
    write_cfg(bpa_pkg::CFG_RESV1_FIRST, bpa_pkg::ResvFirstRst);
    write_cfg(bpa_pkg::CFG_RESV1_LAST, bpa_pkg::ResvLastRst);
    write_cfg(bpa_pkg::CFG_RESV2_FIRST, bpa_pkg::ResvFirstRst);
    write_cfg(bpa_pkg::CFG_RESV2_LAST, bpa_pkg::ResvLastRst);
  endtask

  task automatic test_alloc_free_basic();
    repeat (3) send_req(bpa_pkg::REQ_ALLOC, '0);
    send_req(bpa_pkg::REQ_FREE, 20'd1);
    send_req(bpa_pkg::REQ_FREE, 20'd1);
    send_req(bpa_pkg::REQ_FREE, bpa_pkg::KernFirst);
    send_req(bpa_pkg::REQ_FREE, 20'hFFFFF);
    send_req(bpa_pkg::REQ_FREE, 20'h10000);
    send_req(bpa_pkg::REQ_ALLOC, 20'hFFFFF);
  endtask

  task automatic test_count_extremes();
    write_cfg(bpa_pkg::CFG_PAGE_COUNT, 20'd0);
    send_req(bpa_pkg::REQ_ALLOC, '0);
    send_req(bpa_pkg::REQ_FREE, 20'd0);
    // count beyond the bitmap is clipped
    write_cfg(bpa_pkg::CFG_PAGE_COUNT, 20'hFFFFF);
    send_req(bpa_pkg::REQ_FREE, 20'd65535);
    send_req(bpa_pkg::REQ_FREE, 20'd65536);
    // ignored index must not disturb the count
    write_cfg(bpa_pkg::cfg_idx_e'(CfgIdxUnused), 20'd0);
    write_cfg(bpa_pkg::CFG_PAGE_COUNT, 20'd40);
    repeat (40) send_req(bpa_pkg::REQ_ALLOC, '0);
    send_req(bpa_pkg::REQ_FREE, 20'd39);
    send_req(bpa_pkg::REQ_FREE, 20'd40);
  endtask

  task automatic test_reserved_ranges();
    // allocated pages that later fall in a range stay set
    write_cfg(bpa_pkg::CFG_RESV0_FIRST, 20'd0);
    write_cfg(bpa_pkg::CFG_RESV0_LAST, 20'd3);
    send_req(bpa_pkg::REQ_FREE, 20'd0);
    send_req(bpa_pkg::REQ_FREE, 20'd39);
    write_cfg(bpa_pkg::CFG_RESV1_FIRST, 20'd10);
    write_cfg(bpa_pkg::CFG_RESV1_LAST, 20'd9);
    send_req(bpa_pkg::REQ_FREE, 20'd10);
    send_req(bpa_pkg::REQ_ALLOC, '0);
    write_cfg(bpa_pkg::CFG_PAGE_COUNT, 20'd65536);
    write_cfg(bpa_pkg::CFG_RESV2_FIRST, 20'd0);
    write_cfg(bpa_pkg::CFG_RESV2_LAST, 20'hFFFFF);
    // full scan finds nothing
    send_req(bpa_pkg::REQ_ALLOC, '0);
    clear_ranges();
  endtask

  task automatic test_random(int unsigned n_items);
    int unsigned sel;
    int unsigned k;
    int unsigned cnt;
    for (int unsigned ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 68;
        default: idle_pct = 8;
      endcase
      cnt = ($urandom_range(9) == 0) ? $urandom_range(65536) : $urandom_range(600, 24);
      write_cfg(bpa_pkg::CFG_PAGE_COUNT, {3'($urandom), bpa_pkg::CountW'(cnt)});
      for (int r = 0; r < 3; r++) begin
        k = $urandom_range(cnt + 8);
        write_cfg(bpa_pkg::cfg_idx_e'(bpa_pkg::CFG_RESV0_FIRST + 2 * r), bpa_pkg::PageW'(k));
        write_cfg(bpa_pkg::cfg_idx_e'(bpa_pkg::CFG_RESV0_LAST + 2 * r),
                  bpa_pkg::PageW'(($urandom_range(3) == 0) ? k - 1
                                                           : k + $urandom_range(12)));
      end
      for (int unsigned i = 0; i < n_items / 6; i++) begin
        sel = $urandom_range(99);
        if (sel < 50) begin
          send_req(bpa_pkg::REQ_ALLOC, bpa_pkg::PageW'($urandom));
        end else if (sel < 85 && granted_q.size() != 0) begin
          k = $urandom_range(granted_q.size() - 1);
          send_req(bpa_pkg::REQ_FREE, bpa_pkg::PageW'(granted_q[k]));
          granted_q.delete(k);
        end else if (sel < 93) begin
          send_req(bpa_pkg::REQ_FREE, bpa_pkg::PageW'($urandom_range(cnt + 8)));
        end else begin
          send_req(bpa_pkg::REQ_FREE, bpa_pkg::PageW'($urandom));
        end
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_wdata_i = '0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    idle_pct    = 0;
    page_count  = bpa_pkg::PageCountRst;
    for (int r = 0; r < 3; r++) begin
      resv_first[r] = bpa_pkg::ResvFirstRst;
      resv_last[r]  = bpa_pkg::ResvLastRst;
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_alloc_free_basic();
    test_count_extremes();
    test_reserved_ranges();
    test_random(234);

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ram.sv
hw/rtl/bpa_datapath.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bitmap_page_allocator_unit.sv
sim/tb_bitmap_page_allocator_unit.sv
